[hdl/wcg_pkg.sv]
// ----------------------------------------------------------------------------
// wcg_pkg
// Shared types, constants and coefficient tables of the window generator.
// ----------------------------------------------------------------------------
package wcg_pkg;

    // Field and register widths
    localparam int IDX_W          = 12;
    localparam int LEN_W          = 13;
    localparam int TYPE_W         = 3;
    localparam int COEF_W         = 18;
    localparam int CFG_W          = LEN_W;
    localparam int MAX_LENGTH     = 4096;
    localparam int COEF_FRAC_BITS = 16;

    // Internal fixed point: Q30
    localparam int Q_BITS    = 30;
    localparam int RND_SHIFT = Q_BITS - COEF_FRAC_BITS;
    localparam int COEF_MAX  = 131071;
    localparam int COEF_MIN_MAG = 131072;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);

    // Divider geometry: divisor is 2m, quotient is a 32-bit turn angle (or the Bartlett coefficient)
    localparam int DIVS_W     = LEN_W + 1;
    localparam int QUO_W      = 32;
    localparam int DIVD_W     = DIVS_W + QUO_W;
    localparam int DIV_STAGES = QUO_W;

    // Cosine lane: three setup stages, three per series step, one output
    localparam int SERIES_STEPS = 7;
    localparam int COS_LAT      = 3 + 3 * SERIES_STEPS + 1;
    localparam int COS_TERMS    = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the config port
    localparam logic [0:0] REG_TYPE   = 1'b0;
    localparam logic [0:0] REG_LENGTH = 1'b1;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = LEN_W'(1024);

    typedef enum logic [TYPE_W-1:0] {
        WT_RECT     = 3'd0,
        WT_BARTLETT = 3'd1,
        WT_HANN     = 3'd2,
        WT_HAMMING  = 3'd3,
        WT_BLACKMAN = 3'd4,
        WT_NUTTALL  = 3'd5
    } window_t;

    // Sideband that rides along with an item
    typedef struct packed {
        logic               terr;
        logic               ierr;
        logic [TYPE_W-1:0]  wtype;
        logic [DIVS_W-1:0]  divisor;
    } side_t;

    typedef struct packed {
        logic [DIVD_W-1:0]  dividend;
        side_t              side;
    } entry_t;

    localparam logic [30:0] Q_ONE       = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

    // Elaboration only: millionths to Q30, rounded
    function automatic logic [Q_BITS-1:0] coef_q30(input longint unsigned micro);
        return Q_BITS'(((micro << 30) + 64'd500000) / 64'd1000000);
    endfunction

    // [window - Hann][term]
    localparam logic [Q_BITS-1:0] COEF_Q30 [4][4] = '{
        '{coef_q30(500000), coef_q30(500000), '0, '0},
        '{coef_q30(538360), coef_q30(461640), '0, '0},
        '{coef_q30(420000), coef_q30(500000), coef_q30(80000), '0},
        '{coef_q30(355768), coef_q30(487396), coef_q30(144232), coef_q30(12604)}
    };

    localparam logic [7:0] SERIES_DIV [SERIES_STEPS] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };

    // floor(2^32 / d), exact quotient after one correction
    localparam logic [31:0] SERIES_RECIP [SERIES_STEPS] = '{
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

endpackage

[hdl/wcg_front.sv]
// ----------------------------------------------------------------------------
// wcg_front
// Config registers, item accept, range checks and divider operand setup.
// ----------------------------------------------------------------------------
module wcg_front
    import wcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              full,
    input  logic [IDX_W-1:0]  sample_index,
    input  logic              cfg_write,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              push,
    output entry_t            entry
);

    logic [TYPE_W-1:0] type_reg;
    logic [LEN_W-1:0]  length_reg;

    logic [LEN_W-1:0]  m_eff;
    logic [LEN_W:0]    half;
    logic [LEN_W-1:0]  num;
    logic [DIVS_W-1:0] two_m;
    logic [DIVS_W-1:0] phase_sum;
    logic [DIVS_W-1:0] n1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg   <= WT_RECT;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_TYPE)
                type_reg <= cfg_data[TYPE_W-1:0];
            else if (cfg_index == REG_LENGTH)
                length_reg <= cfg_data[LEN_W-1:0];
        end
    end

    always_comb
    begin
        m_eff = (length_reg > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : length_reg;
        half  = ({1'b0, m_eff} + 1'b1) >> 1;
        // Bartlett: rising half uses i, falling half uses m - i
        num   = ({2'b0, sample_index} < half) ? {1'b0, sample_index}
                                              : m_eff - {1'b0, sample_index};
        two_m = {m_eff, 1'b0};
        // first cosine harmonic phase: (2i + m) mod 2m
        phase_sum = {1'b0, sample_index, 1'b0} + {1'b0, m_eff};
        n1        = (phase_sum >= two_m) ? phase_sum - two_m : phase_sum;

        entry.side.terr    = type_reg > WT_NUTTALL;
        entry.side.ierr    = {1'b0, sample_index} >= m_eff;
        entry.side.wtype   = type_reg;
        entry.side.divisor = two_m;
        if (type_reg == WT_BARTLETT)
            entry.dividend = DIVD_W'({num, (COEF_FRAC_BITS + 2)'(0)}) + DIVD_W'(m_eff);
        else
            entry.dividend = {n1, QUO_W'(0)};

        push = start && !full;
    end

endmodule

[hdl/wcg_queue.sv]
// ----------------------------------------------------------------------------
// wcg_queue
// Short item queue between front and back; back drains it every cycle.
// ----------------------------------------------------------------------------
module wcg_queue
    import wcg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   out_valid,
    output entry_t out_entry
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    always_comb
    begin
        pop         = count_reg != '0;
        full        = count_reg == QCNT_W'(QUEUE_DEPTH);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
        out_valid  = pop;
        out_entry  = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // back side takes an item every cycle, so one slot is all that fills
    a_drain: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= QCNT_W'(1))
        else $error("queue holds more than one item");

endmodule

[hdl/wcg_divider.sv]
// ----------------------------------------------------------------------------
// wcg_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module wcg_divider
    import wcg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  entry_t             in_entry,
    output logic               out_valid,
    output logic [QUO_W-1:0]   quotient,
    output logic [DIVS_W-1:0]  remainder,
    output side_t              out_side
);

    logic              valid_st [DIV_STAGES+1];
    logic [DIVS_W-1:0] rem_st   [DIV_STAGES+1];
    logic [QUO_W-1:0]  low_st   [DIV_STAGES+1];
    logic [QUO_W-1:0]  quo_st   [DIV_STAGES+1];
    side_t             side_st  [DIV_STAGES+1];

    assign valid_st[0] = in_valid;
    assign rem_st[0]   = in_entry.dividend[DIVD_W-1:QUO_W];
    assign low_st[0]   = in_entry.dividend[QUO_W-1:0];
    assign quo_st[0]   = '0;
    assign side_st[0]  = in_entry.side;

    for (genvar b = 0; b < DIV_STAGES; b++)
    begin : g_stage
        logic              valid_reg;
        logic [DIVS_W-1:0] rem_reg;
        logic [QUO_W-1:0]  low_reg;
        logic [QUO_W-1:0]  quo_reg;
        side_t             side_reg;
        logic [DIVS_W:0]   trial;
        logic              fits;

        assign trial = {rem_st[b], low_st[b][QUO_W-1]};
        assign fits  = trial >= {1'b0, side_st[b].divisor};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else
                valid_reg <= valid_st[b];
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= fits ? DIVS_W'(trial - {1'b0, side_st[b].divisor})
                             : trial[DIVS_W-1:0];
            low_reg  <= {low_st[b][QUO_W-2:0], 1'b0};
            quo_reg  <= {quo_st[b][QUO_W-2:0], fits};
            side_reg <= side_st[b];
        end

        assign valid_st[b+1] = valid_reg;
        assign rem_st[b+1]   = rem_reg;
        assign low_st[b+1]   = low_reg;
        assign quo_st[b+1]   = quo_reg;
        assign side_st[b+1]  = side_reg;
    end

    assign out_valid = valid_st[DIV_STAGES];
    assign quotient  = quo_st[DIV_STAGES];
    assign remainder = rem_st[DIV_STAGES];
    assign out_side  = side_st[DIV_STAGES];

endmodule

[hdl/wcg_cosine.sv]
// ----------------------------------------------------------------------------
// wcg_cosine
// Pipelined Q30 cosine of a 32-bit turn angle (quadrant fold + Horner series).
// ----------------------------------------------------------------------------
module wcg_cosine
    import wcg_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        angle,
    output logic signed [31:0] cosine
);

    logic [1:0]  quad;
    logic [29:0] frac;
    logic [61:0] x_prod;
    logic [61:0] x2_prod;

    logic [30:0] rr_reg;
    logic        neg_a_reg;
    logic [30:0] x_reg;
    logic        neg_b_reg;
    logic [31:0] x2_reg;
    logic        neg_c_reg;
    logic signed [31:0] cosine_reg;

    logic [31:0]        x2_st  [SERIES_STEPS+1];
    logic signed [31:0] t_st   [SERIES_STEPS+1];
    logic               neg_st [SERIES_STEPS+1];

    assign quad    = angle[31:30];
    assign frac    = angle[29:0];
    assign x_prod  = rr_reg * HALF_PI_Q30;
    assign x2_prod = x_reg * x_reg;

    always_ff @(posedge clk)
    begin
        // quadrants 1 and 3 mirror the offset, 1 and 2 flip the sign
        rr_reg    <= quad[0] ? Q_ONE - {1'b0, frac} : {1'b0, frac};
        neg_a_reg <= quad[1] ^ quad[0];
        x_reg     <= x_prod[60:30];
        neg_b_reg <= neg_a_reg;
        x2_reg    <= x2_prod[61:30];
        neg_c_reg <= neg_b_reg;
    end

    assign x2_st[0]  = x2_reg;
    assign t_st[0]   = signed'({1'b0, Q_ONE});
    assign neg_st[0] = neg_c_reg;

    // t = 1 - x^2 * t / d, three stages per step
    for (genvar j = 0; j < SERIES_STEPS; j++)
    begin : g_step
        logic [62:0] p_prod;
        logic [63:0] q_prod;
        logic [39:0] back_prod;
        logic [32:0] resid;
        logic [31:0] quo;

        logic [31:0] p_reg, x2_p_reg;
        logic        neg_p_reg;
        logic [31:0] q0_reg, pq_reg, x2_q_reg;
        logic        neg_q_reg;
        logic signed [31:0] t_reg;
        logic [31:0] x2_t_reg;
        logic        neg_t_reg;

        assign p_prod    = x2_st[j] * t_st[j][30:0];
        assign q_prod    = p_reg * SERIES_RECIP[j];
        assign back_prod = q0_reg * SERIES_DIV[j];
        assign resid     = {1'b0, pq_reg} - 33'(back_prod);
        assign quo       = q0_reg + 32'(resid >= 33'(SERIES_DIV[j]));

        always_ff @(posedge clk)
        begin
            p_reg     <= p_prod[61:30];
            x2_p_reg  <= x2_st[j];
            neg_p_reg <= neg_st[j];
            q0_reg    <= q_prod[63:32];
            pq_reg    <= p_reg;
            x2_q_reg  <= x2_p_reg;
            neg_q_reg <= neg_p_reg;
            t_reg     <= signed'({1'b0, Q_ONE}) - signed'(quo);
            x2_t_reg  <= x2_q_reg;
            neg_t_reg <= neg_q_reg;
        end

        assign x2_st[j+1]  = x2_t_reg;
        assign t_st[j+1]   = t_reg;
        assign neg_st[j+1] = neg_t_reg;
    end

    always_ff @(posedge clk)
    begin
        cosine_reg <= neg_st[SERIES_STEPS] ? -t_st[SERIES_STEPS] : t_st[SERIES_STEPS];
    end

    assign cosine = cosine_reg;

endmodule

[hdl/wcg_back.sv]
// ----------------------------------------------------------------------------
// wcg_back
// Divider, harmonic angles, cosine lanes, weighted sum and output register.
// ----------------------------------------------------------------------------
module wcg_back
    import wcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  entry_t                   in_entry,
    output logic                     done,
    output logic signed [COEF_W-1:0] coefficient,
    output logic                     type_error,
    output logic                     index_error
);

    typedef struct packed {
        logic              terr;
        logic              ierr;
        logic [TYPE_W-1:0] wtype;
        logic [COEF_W-1:0] lin;
    } tail_t;

    logic              dv_valid;
    logic [QUO_W-1:0]  dv_quo;
    logic [DIVS_W-1:0] dv_rem;
    side_t             dv_side;

    wcg_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_entry  (in_entry),
        .out_valid (dv_valid),
        .quotient  (dv_quo),
        .remainder (dv_rem),
        .out_side  (dv_side)
    );

    // ---- harmonic angles: A_k = k*q + floor(k*rem / 2m)
    logic [DIVS_W:0]   rem2;
    logic [DIVS_W+1:0] rem3;
    logic              c2;
    logic [1:0]        c3;
    tail_t             tail_a;

    logic              ang_valid_reg;
    logic [31:0]       ang_reg [COS_TERMS];
    tail_t             tail_a_reg;

    always_comb
    begin
        rem2 = {dv_rem, 1'b0};
        rem3 = (DIVS_W+2)'(rem2) + (DIVS_W+2)'(dv_rem);
        c2   = rem2 >= {1'b0, dv_side.divisor};
        if (rem3 >= (DIVS_W+2)'({dv_side.divisor, 1'b0}))
            c3 = 2'd2;
        else if (rem3 >= (DIVS_W+2)'(dv_side.divisor))
            c3 = 2'd1;
        else
            c3 = 2'd0;
        tail_a.terr  = dv_side.terr;
        tail_a.ierr  = dv_side.ierr;
        tail_a.wtype = dv_side.wtype;
        if (dv_side.wtype == WT_RECT)
            tail_a.lin = COEF_ONE;
        else if (dv_quo > QUO_W'(COEF_MAX))
            tail_a.lin = COEF_W'(COEF_MAX);
        else
            tail_a.lin = dv_quo[COEF_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_valid_reg <= 1'b0;
        else
            ang_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        ang_reg[0] <= dv_quo;
        ang_reg[1] <= {dv_quo[30:0], 1'b0} + 32'(c2);
        ang_reg[2] <= {dv_quo[30:0], 1'b0} + dv_quo + 32'(c3);
        tail_a_reg <= tail_a;
    end

    // ---- cosine lanes, one per harmonic
    logic signed [31:0] cos_w [COS_TERMS];

    for (genvar k = 0; k < COS_TERMS; k++)
    begin : g_lane
        wcg_cosine u_cos (
            .clk    (clk),
            .angle  (ang_reg[k]),
            .cosine (cos_w[k])
        );
    end

    // ---- sideband delay to match the lanes
    logic  vdly_reg [COS_LAT];
    tail_t tdly_reg [COS_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < COS_LAT; s++)
                vdly_reg[s] <= 1'b0;
        end
        else
        begin
            vdly_reg[0] <= ang_valid_reg;
            for (int s = 1; s < COS_LAT; s++)
                vdly_reg[s] <= vdly_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        tdly_reg[0] <= tail_a_reg;
        for (int s = 1; s < COS_LAT; s++)
            tdly_reg[s] <= tdly_reg[s-1];
    end

    // ---- a_k * cos, truncated toward zero
    tail_t              tail_l;
    logic [1:0]         sel;
    logic signed [31:0] term [COS_TERMS];

    logic               prod_valid_reg;
    logic [Q_BITS-1:0]  a0_reg;
    logic signed [31:0] term_reg [COS_TERMS];
    tail_t              tail_p_reg;

    assign tail_l = tdly_reg[COS_LAT-1];
    assign sel    = 2'(tail_l.wtype - WT_HANN);

    for (genvar k = 0; k < COS_TERMS; k++)
    begin : g_term
        logic [31:0] cmag;
        logic [60:0] prod;
        logic [30:0] pmag;

        assign cmag    = cos_w[k][31] ? 32'(-cos_w[k]) : 32'(cos_w[k]);
        assign prod    = COEF_Q30[sel][k+1] * cmag[30:0];
        assign pmag    = prod[60:30];
        assign term[k] = cos_w[k][31] ? -signed'({1'b0, pmag}) : signed'({1'b0, pmag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= vdly_reg[COS_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        a0_reg     <= COEF_Q30[sel][0];
        term_reg   <= term;
        tail_p_reg <= tail_l;
    end

    // ---- Q30 sum
    logic               sum_valid_reg;
    logic signed [33:0] w_reg;
    tail_t              tail_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else
            sum_valid_reg <= prod_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        w_reg <= signed'(34'(a0_reg)) + 34'(term_reg[0]) + 34'(term_reg[1])
                 + 34'(term_reg[2]);
        tail_s_reg <= tail_p_reg;
    end

    // ---- round half away from zero, saturate, select result
    logic                     w_neg;
    logic [33:0]              w_mag;
    logic [33:0]              r_mag;
    logic signed [COEF_W-1:0] cos_val;
    logic signed [COEF_W-1:0] coef_next;

    logic                     done_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic                     terr_reg;
    logic                     ierr_reg;

    always_comb
    begin
        w_neg = w_reg[33];
        w_mag = w_neg ? 34'(-w_reg) : 34'(w_reg);
        r_mag = (w_mag + (34'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
        if (!w_neg)
            cos_val = (r_mag > 34'(COEF_MAX)) ? COEF_W'(COEF_MAX) : COEF_W'(r_mag);
        else if (r_mag > 34'(COEF_MIN_MAG))
            cos_val = COEF_W'(-COEF_MIN_MAG);
        else
            cos_val = COEF_W'(-signed'(r_mag));

        if (tail_s_reg.terr || tail_s_reg.ierr)
            coef_next = '0;
        else if (tail_s_reg.wtype >= WT_HANN)
            coef_next = cos_val;
        else
            coef_next = signed'(tail_s_reg.lin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sum_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        terr_reg <= tail_s_reg.terr;
        ierr_reg <= tail_s_reg.ierr;
    end

    assign done        = done_reg;
    assign coefficient = coef_reg;
    assign type_error  = terr_reg;
    assign index_error = ierr_reg;

endmodule

[hdl/window_coefficient_generator.sv]
// ----------------------------------------------------------------------------
// window_coefficient_generator
// Window coefficient per sample index: rectangular, Bartlett, Hann, Hamming,
// Blackman and Nuttall, signed fixed point with 1.0 = 65536.
// ----------------------------------------------------------------------------
//
//  channel   ports                                      handshake
//  -------   -----------------------------------------  ---------------------
//  item in   sample_index                               start && !busy
//  result    coefficient, type_error, index_error       done, one cycle
//  config    cfg_index (0 type, 1 length), cfg_data     cfg_write, no wait
//
//  One item per clock. Each item's result shows on done once the item has
//  passed the pipeline, and is taken by the receiver at the edge after that.
//  The depth is set by the 32-stage divider (one quotient bit per stage,
//  divisor 2m) and the 25-stage cosine lanes (three setup stages, seven
//  series steps of three stages each, one output stage), plus the angle,
//  product, sum and output registers.
//  Reset clears the valid pipeline and loads type 0, length 1024; no
//  clearing pass is needed. Results cannot be held off, and busy only
//  rises if the front queue fills.
// ----------------------------------------------------------------------------
module window_coefficient_generator
    import wcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [IDX_W-1:0]         sample_index,
    input  logic                     cfg_write,
    input  logic [0:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    output logic                     done,
    output logic signed [COEF_W-1:0] coefficient,
    output logic                     type_error,
    output logic                     index_error
);

    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   q_valid;
    entry_t q_entry;

    // front: config registers, range checks, divider operands
    wcg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .full         (q_full),
        .sample_index (sample_index),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .entry        (push_entry)
    );

    // short queue decouples the item port from the arithmetic
    wcg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .out_valid  (q_valid),
        .out_entry  (q_entry)
    );

    // back: divider, cosine lanes, weighted sum, rounding
    wcg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_entry    (q_entry),
        .done        (done),
        .coefficient (coefficient),
        .type_error  (type_error),
        .index_error (index_error)
    );

    assign busy = q_full;

    // either error forces a zero coefficient
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (type_error || index_error) |-> coefficient == '0)
        else $error("error result with nonzero coefficient");

    // back never falls behind, so the item port never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("item port stalled");

endmodule

[tb/tb_window_coefficient_generator.sv]
// ----------------------------------------------------------------------------
// tb_window_coefficient_generator
// Self-checking bench: directed table then random indexes over all window
// types and random lengths; each coefficient is predicted (cosine windows in Q30) and compared.
// ----------------------------------------------------------------------------
module tb_window_coefficient_generator;
    import wcg_pkg::*;

    // Expected result of one item
    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic                     terr;
        logic                     ierr;
    } coef_exp_t;

    // Directed stimulus row; has_exp marks rows with a typed-in value
    typedef struct {
        logic [TYPE_W-1:0] wtype;
        logic [LEN_W-1:0]  wlen;
        logic [IDX_W-1:0]  idx;
        bit                has_exp;
        coef_exp_t         exp_val;
    } dir_row_t;

    localparam int LATENCY = 62;
    localparam int N_RANDOM = 1800;
    localparam longint Q1 = longint'(1) << 30;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [IDX_W-1:0] sample_index;
    logic cfg_write;
    logic [0:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic done;
    logic signed [COEF_W-1:0] coefficient;
    logic type_error;
    logic index_error;

    // Model copy of the configuration registers
    logic [TYPE_W-1:0] cur_type;
    logic [LEN_W-1:0]  cur_len;

    coef_exp_t pending_coefs[$];
    int n_fail;
    int n_items;
    int n_results;
    bit [7:0] types_seen;

    window_coefficient_generator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sample_index(sample_index), .cfg_write(cfg_write),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
        .coefficient(coefficient), .type_error(type_error),
        .index_error(index_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Safety net: well beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $display("timeout: %0d results still pending", pending_coefs.size());
        $finish;
    end

    // Q30 product, magnitude truncated toward zero
    function automatic longint q30_mul(input longint a, input longint b);
        longint unsigned p;
        p = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Cosine of r quarter-turn units via truncated Taylor series
    function automatic longint quarter_cos(input longint unsigned r);
        longint x;
        longint x2;
        longint t;
        longint dv [7];
        dv = '{182, 132, 90, 56, 30, 12, 2};
        x = longint'((r * 64'h6487ED51) >> 30);
        x2 = q30_mul(x, x);
        t = Q1;
        for (int j = 0; j < 7; j++)
            t = Q1 - q30_mul(x2, t) / dv[j];
        return t;
    endfunction

    function automatic longint turn_cos(input logic [31:0] a);
        longint unsigned r;
        r = a[29:0];
        case (a[31:30])
            2'd0: return quarter_cos(r);
            2'd1: return -quarter_cos(Q1 - r);
            2'd2: return -quarter_cos(r);
            default: return quarter_cos(Q1 - r);
        endcase
    endfunction

    function automatic longint micro_to_q30(input longint unsigned u);
        return longint'(((u << 30) + 500000) / 1000000);
    endfunction

    // Expected coefficient and flags for one index under current config
    function automatic coef_exp_t window_coef(input logic [TYPE_W-1:0] wt,
                                              input logic [LEN_W-1:0] wl,
                                              input logic [IDX_W-1:0] ix);
        coef_exp_t e;
        longint unsigned m;
        longint unsigned i;
        longint unsigned num;
        longint unsigned n;
        longint unsigned mag;
        longint unsigned mic [4][4];
        int nterm;
        int sel;
        longint w;
        logic [31:0] ang;
        mic = '{'{500000, 500000, 0, 0}, '{538360, 461640, 0, 0},
                '{420000, 500000, 80000, 0}, '{355768, 487396, 144232, 12604}};
        m = (wl > MAX_LENGTH) ? MAX_LENGTH : wl;
        i = ix;
        e.terr = (wt > WT_NUTTALL);
        e.ierr = (i >= m);
        e.coef = '0;
        if (!e.terr && !e.ierr)
        begin
            if (wt == WT_RECT)
                e.coef = COEF_W'(65536);
            else if (wt == WT_BARTLETT)
            begin
                num = (i < (m + 1) / 2) ? i : m - i;
                e.coef = COEF_W'((4 * num * 65536 + m) / (2 * m));
            end
            else
            begin
                sel = int'(wt) - 2;
                nterm = (sel == 3) ? 4 : (sel == 2) ? 3 : 2;
                w = micro_to_q30(mic[sel][0]);
                for (int k = 1; k < nterm; k++)
                begin
                    n = (longint'(k) * (2 * i + m)) % (2 * m);
                    ang = 32'((n << 32) / (2 * m));
                    w += q30_mul(micro_to_q30(mic[sel][k]), turn_cos(ang));
                end
                mag = ((w < 0 ? -w : w) + (1 << 13)) >> 14;
                e.coef = COEF_W'(w < 0 ? -longint'(mag) : longint'(mag));
            end
        end
        return e;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        n_fail++;
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 n_results, what, got, want);
    endtask

    // Result side: cannot stall, so check every done cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_coefs.size() == 0)
                report_mismatch("unexpected result", coefficient, 0);
            else
            begin
                coef_exp_t e;
                e = pending_coefs.pop_front();
                if (coefficient !== e.coef)
                    report_mismatch("coefficient", coefficient, e.coef);
                if (type_error !== e.terr)
                    report_mismatch("type_error", type_error, e.terr);
                if (index_error !== e.ierr)
                    report_mismatch("index_error", index_error, e.ierr);
            end
            n_results++;
        end
    end

    // Register write while idle
    task automatic write_reg(input logic [0:0] ri, input logic [CFG_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (ri == REG_TYPE)
            cur_type = v[TYPE_W-1:0];
        else
            cur_len = v;
    endtask

    // Wait for all outstanding results plus pipeline drain
    task automatic drain_all();
        while (pending_coefs.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_window(input logic [TYPE_W-1:0] wt,
                              input logic [LEN_W-1:0] wl);
        drain_all();
        if (wt != cur_type)
            write_reg(REG_TYPE, CFG_W'(wt));
        if (wl != cur_len)
            write_reg(REG_LENGTH, wl);
        types_seen[wt] = 1'b1;
    endtask

    // Present one item; start stays high across back-to-back items
    task automatic send_index(input logic [IDX_W-1:0] ix, input bit has_exp,
                              input coef_exp_t ev);
        start <= 1'b1;
        sample_index <= ix;
        do
            @(posedge clk);
        while (busy);
        pending_coefs.push_back(has_exp ? ev : window_coef(cur_type, cur_len, ix));
        n_items++;
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        sample_index <= IDX_W'($urandom);
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return LEN_W'(4096);
        if (r == 1)
            return LEN_W'($urandom_range(4097, 8191));
        if (r == 2)
            return LEN_W'($urandom_range(0, 2));
        return LEN_W'($urandom_range(3, 300));
    endfunction

    dir_row_t dir_tab [$];
    coef_exp_t none_exp;
    logic [LEN_W-1:0] rl;
    logic [TYPE_W-1:0] rt;
    int burst;
    logic [IDX_W-1:0] ri;

    initial
    begin
        none_exp = '{coef: '0, terr: 1'b0, ierr: 1'b0};
        // Directed table: reset values, extremes, every type, both errors
        dir_tab = '{
            '{WT_RECT, 1024, 0, 1, '{COEF_W'(65536), 0, 0}},
            '{WT_RECT, 1024, 1023, 1, '{COEF_W'(65536), 0, 0}},
            '{WT_RECT, 1024, 1024, 1, '{0, 0, 1}},
            '{WT_RECT, 1024, 4095, 1, '{0, 0, 1}},
            '{WT_BARTLETT, 8, 0, 1, '{0, 0, 0}},
            '{WT_BARTLETT, 8, 4, 1, '{COEF_W'(65536), 0, 0}},
            '{WT_BARTLETT, 7, 3, 0, none_exp},
            '{WT_HANN, 16, 0, 1, '{0, 0, 0}},
            '{WT_HANN, 16, 8, 0, none_exp},
            '{WT_HANN, 16, 5, 0, none_exp},
            '{WT_HAMMING, 1, 0, 0, none_exp},
            '{WT_HAMMING, 4096, 4095, 0, none_exp},
            '{WT_HAMMING, 4096, 2048, 0, none_exp},
            '{WT_BLACKMAN, 2, 1, 0, none_exp},
            '{WT_BLACKMAN, 100, 0, 0, none_exp},
            '{WT_NUTTALL, 33, 16, 0, none_exp},
            '{WT_NUTTALL, 33, 0, 0, none_exp},
            '{WT_NUTTALL, 8191, 4095, 0, none_exp},
            '{WT_NUTTALL, 0, 0, 1, '{0, 0, 1}},
            '{3'd6, 64, 3, 1, '{0, 1, 0}},
            '{3'd7, 64, 64, 1, '{0, 1, 1}},
            '{3'd7, 8191, 2730, 1, '{0, 1, 0}}
        };
        n_fail = 0;
        n_items = 0;
        n_results = 0;
        types_seen = '0;
        rst_n = 1'b0;
        start = 1'b0;
        sample_index = '0;
        cfg_write = 1'b0;
        cfg_index = REG_TYPE;
        cfg_data = '0;
        cur_type = WT_RECT;
        cur_len = LENGTH_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[r])
        begin
            if (dir_tab[r].wtype != cur_type || dir_tab[r].wlen != cur_len)
            begin
                idle_cycles(1);
                set_window(dir_tab[r].wtype, dir_tab[r].wlen);
            end
            send_index(dir_tab[r].idx, dir_tab[r].has_exp, dir_tab[r].exp_val);
        end
        idle_cycles(1);

        // Random phases: new config, then bursts of indexes with gaps
        while (n_items < N_RANDOM + dir_tab.size())
        begin
            rt = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom_range(6, 7))
                                             : TYPE_W'($urandom_range(0, 5));
            rl = pick_length();
            set_window(rt, rl);
            for (int b = 0; b < 8; b++)
            begin
                burst = $urandom_range(1, 20);
                for (int j = 0; j < burst; j++)
                begin
                    // mostly in range, some beyond the length
                    if ($urandom_range(0, 7) == 0 || rl == 0)
                        ri = IDX_W'($urandom);
                    else
                        ri = IDX_W'($urandom_range(0, (rl > 4096 ? 4096 : rl) - 1));
                    send_index(ri, 0, none_exp);
                end
                if ($urandom_range(0, 2) != 0)
                    idle_cycles($urandom_range(1, 12));
            end
            idle_cycles(1);
        end

        drain_all();
        $display("Covered %0d items, %0d results; window types hit mask %b.",
                 n_items, n_results, types_seen);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/wcg_pkg.sv
hdl/wcg_front.sv
hdl/wcg_queue.sv
hdl/wcg_divider.sv
hdl/wcg_cosine.sv
hdl/wcg_back.sv
hdl/window_coefficient_generator.sv
tb/tb_window_coefficient_generator.sv
